[rtl/core/fmpp_pkg.sv]
// Package with the shared types, codes and helper functions of the prefix policy table.
`timescale 1ns / 1ps
package fmpp_pkg;

    // Opcodes of an input transaction.
    localparam logic [2:0] OP_EVAL   = 3'd0;
    localparam logic [2:0] OP_BEGIN  = 3'd1;
    localparam logic [2:0] OP_GROUP  = 3'd2;
    localparam logic [2:0] OP_SOURCE = 3'd3;
    localparam logic [2:0] OP_APPEND = 3'd4;
    localparam logic [2:0] OP_COMMIT = 3'd5;

    // Action codes.
    localparam logic [1:0] ACT_ACCEPT = 2'd0;
    localparam logic [1:0] ACT_NEXT   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Longest legal prefix.
    localparam logic [7:0] MAX_PREFIX = 8'd128;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic        src_present;
        logic [7:0]  prefix_len;
        logic        clause_present;
        logic [1:0]  action;
        logic [31:0] entry_number;
        logic [31:0] entry_term;
    } t_item;

    typedef struct packed {
        logic [1:0] result_action;
        logic [1:0] status;
    } t_result;

    // Command class decided by the front end.
    typedef enum logic [2:0] {
        K_EVAL,
        K_BEGIN,
        K_GROUP,
        K_SOURCE,
        K_APPEND,
        K_COMMIT,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_item item;
    } t_cmd;

    // Stored prefix clause.
    typedef struct packed {
        logic [127:0] net;
        logic [7:0]   len;
    } t_clause;

    // Per-entry flags and action.
    typedef struct packed {
        logic       gused;
        logic       sused;
        logic [1:0] action;
    } t_meta;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // Network mask for a prefix length; lengths of 128 and more give all ones.
    function automatic logic [127:0] prefix_mask(input logic [7:0] len);
        prefix_mask = ~({128{1'b1}} >> len);
    endfunction

    // Sort an opcode into its command class.
    function automatic t_kind classify(input logic [2:0] op);
        t_kind k;
        unique case (op)
            OP_EVAL:   k = K_EVAL;
            OP_BEGIN:  k = K_BEGIN;
            OP_GROUP:  k = K_GROUP;
            OP_SOURCE: k = K_SOURCE;
            OP_APPEND: k = K_APPEND;
            OP_COMMIT: k = K_COMMIT;
            default:   k = K_BAD;
        endcase
        classify = k;
    endfunction

endpackage

[rtl/core/first_match_prefix_policy.sv]
// Top level of the first-match IPv6 prefix policy table with two banks.
//
//   Channel   Handshake            Payload    Direction
//   input     push / full          i_item     in
//   result    empty / pop          o_result   out
//
// A transaction passes a two-entry command queue into the back end.
// Load, clause, append and commit transactions complete in the back end when taken;
// an evaluate scans the entries of the active bank in order (at most MAX_ENTRIES),
// one entry per cycle from the registered-read table memory, up to the first match.
// Reset is synchronous: both banks empty with default accept; no clearing pass.
// The back end holds its next command while its result register is not taken.
`timescale 1ns / 1ps
module first_match_prefix_policy
    import fmpp_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    // Front end: accept and classify.
    fmpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    // Back end: execute against the banks.
    fmpp_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

[rtl/core/fmpp_front.sv]
// Front end: accepts input transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module fmpp_front
    import fmpp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output t_cmd  o_cmd,
    output logic  o_cmd_valid,
    input  logic  i_cmd_ready
);

    logic [1:0] r_count, n_count;
    logic       r_head, n_head;
    logic       r_tail, n_tail;
    t_cmd       r_slot [2];
    logic       push_ok, pop_ok;

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_head];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = o_cmd_valid && i_cmd_ready;

    // Queue pointers and fill count.
    always_comb begin
        n_head  = pop_ok ? ~r_head : r_head;
        n_tail  = push_ok ? ~r_tail : r_tail;
        n_count = r_count + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    // Store the classified transaction.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_tail] <= '{kind: classify(i_item.opcode), item: i_item};
        end
    end

endmodule

[rtl/core/fmpp_back.sv]
// Back end: executes load commands and scans the active bank for evaluate commands.
`timescale 1ns / 1ps
module fmpp_back
    import fmpp_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int SLOTS = 2 * (2 ** AW);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    t_state        r_state, n_state;
    logic          r_active, n_active;
    logic [CW-1:0] r_count [2];
    logic [CW-1:0] n_count [2];
    logic [1:0]    r_default [2];
    logic [1:0]    n_default [2];
    logic [CW-1:0] r_load_count, n_load_count;
    logic          r_load_error, n_load_error;
    logic [31:0]   r_last_number, n_last_number;
    logic [31:0]   r_last_term, n_last_term;
    logic          r_pend_g, n_pend_g;
    logic          r_pend_s, n_pend_s;
    logic [AW-1:0] r_idx, n_idx;
    logic [127:0]  r_key_addr, n_key_addr;
    logic [127:0]  r_key_src, n_key_src;
    logic          r_key_sp, n_key_sp;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    t_clause r_grp_mem [SLOTS];
    t_clause r_src_mem [SLOTS];
    t_meta   r_meta_mem [SLOTS];
    t_clause r_grp_rd, r_src_rd;
    t_meta   r_meta_rd;

    logic          take, scan_done, start_scan;
    logic [AW:0]   rd_addr, wr_addr;
    logic          grp_we, src_we, meta_we;
    t_clause       clause_wd;
    t_meta         meta_wd;
    logic          inactive;
    logic [127:0]  in_net, in_mask;
    logic          clause_ok, order_bad, match;
    logic [CW-1:0] idx_next;
    t_item         it;

    assign it          = i_cmd.item;
    assign inactive    = ~r_active;
    assign take        = i_cmd_valid && (r_state == S_IDLE) && (!r_out_valid || i_pop);
    assign o_cmd_ready = take;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;
    assign in_net      = {it.addr_hi, it.addr_lo};
    assign in_mask     = prefix_mask(it.prefix_len);
    assign clause_ok   = !it.clause_present ||
                         ((it.prefix_len <= MAX_PREFIX) && ((in_net & ~in_mask) == '0));
    assign order_bad   = (it.entry_number == 32'd0) || (it.entry_number < r_last_number) ||
                         ((it.entry_number == r_last_number) && (it.entry_term <= r_last_term));
    assign idx_next    = CW'(r_idx) + CW'(1);
    assign start_scan  = take && (i_cmd.kind == K_EVAL) && (r_count[r_active] != '0);

    // Match of the entry whose read data is on hand.
    assign match = (!r_meta_rd.gused ||
                    ((r_key_addr & prefix_mask(r_grp_rd.len)) == r_grp_rd.net)) &&
                   (!r_meta_rd.sused ||
                    (r_key_sp && ((r_key_src & prefix_mask(r_src_rd.len)) == r_src_rd.net)));
    assign scan_done = (r_state == S_SCAN) &&
                       ((match && (r_meta_rd.action != ACT_NEXT)) ||
                        (idx_next == r_count[r_active]));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start_scan) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and table updates.
    always_comb begin
        n_active      = r_active;
        n_count       = r_count;
        n_default     = r_default;
        n_load_count  = r_load_count;
        n_load_error  = r_load_error;
        n_last_number = r_last_number;
        n_last_term   = r_last_term;
        n_pend_g      = r_pend_g;
        n_pend_s      = r_pend_s;
        n_idx         = r_idx;
        n_key_addr    = r_key_addr;
        n_key_src     = r_key_src;
        n_key_sp      = r_key_sp;
        n_out_valid   = r_out_valid && !i_pop;
        n_out         = r_out;
        grp_we        = 1'b0;
        src_we        = 1'b0;
        meta_we       = 1'b0;
        clause_wd     = '{net: in_net, len: it.prefix_len};
        meta_wd       = '{gused: r_pend_g, sused: r_pend_s, action: it.action};
        wr_addr       = {inactive, r_load_count[AW-1:0]};
        rd_addr       = {r_active, {AW{1'b0}}};

        if (r_state == S_SCAN) begin
            rd_addr = {r_active, AW'(idx_next)};
            n_idx   = AW'(idx_next);
            if (scan_done) begin
                n_out_valid = 1'b1;
                n_out.status = ST_OK;
                if (match && (r_meta_rd.action != ACT_NEXT)) begin
                    n_out.result_action = r_meta_rd.action;
                end else begin
                    n_out.result_action = r_default[r_active];
                end
            end
        end

        if (take) begin
            n_out_valid = 1'b1;
            n_out       = '{result_action: ACT_ACCEPT, status: ST_OK};
            unique case (i_cmd.kind)
                K_EVAL: begin
                    n_key_addr = {it.addr_hi, it.addr_lo};
                    n_key_src  = {it.src_hi, it.src_lo};
                    n_key_sp   = it.src_present;
                    n_idx      = '0;
                    if (r_count[r_active] != '0) begin
                        n_out_valid = 1'b0;
                    end else begin
                        n_out.result_action = r_default[r_active];
                    end
                end
                K_BEGIN: begin
                    n_load_count  = '0;
                    n_load_error  = 1'b0;
                    n_last_number = '0;
                    n_last_term   = '0;
                    n_pend_g      = 1'b0;
                    n_pend_s      = 1'b0;
                end
                K_GROUP, K_SOURCE: begin
                    if (r_load_count >= MAX_CNT) begin
                        n_load_error = 1'b1;
                        n_out.status = ST_FULL;
                    end else if (!clause_ok) begin
                        n_load_error = 1'b1;
                        n_out.status = ST_INVALID;
                    end else if (i_cmd.kind == K_GROUP) begin
                        grp_we   = 1'b1;
                        n_pend_g = it.clause_present;
                    end else begin
                        src_we   = 1'b1;
                        n_pend_s = it.clause_present;
                    end
                end
                K_APPEND: begin
                    if (r_load_count >= MAX_CNT) begin
                        n_load_error = 1'b1;
                        n_out.status = ST_FULL;
                    end else if (order_bad) begin
                        n_load_error = 1'b1;
                        n_out.status = ST_INVALID;
                    end else begin
                        meta_we       = 1'b1;
                        n_load_count  = r_load_count + CW'(1);
                        n_last_number = it.entry_number;
                        n_last_term   = it.entry_term;
                        n_pend_g      = 1'b0;
                        n_pend_s      = 1'b0;
                    end
                end
                K_COMMIT: begin
                    if (r_load_error || (it.action == ACT_NEXT)) begin
                        n_out.status = ST_INVALID;
                    end else begin
                        n_count[inactive]   = r_load_count;
                        n_default[inactive] = it.action;
                        n_active            = inactive;
                        n_load_error        = 1'b1;
                    end
                end
                default: n_out.status = ST_INVALID;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_active      <= 1'b0;
            r_count[0]    <= '0;
            r_count[1]    <= '0;
            r_default[0]  <= ACT_ACCEPT;
            r_default[1]  <= ACT_ACCEPT;
            r_load_count  <= '0;
            r_load_error  <= 1'b0;
            r_last_number <= '0;
            r_last_term   <= '0;
            r_pend_g      <= 1'b0;
            r_pend_s      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_active      <= n_active;
            r_count       <= n_count;
            r_default     <= n_default;
            r_load_count  <= n_load_count;
            r_load_error  <= n_load_error;
            r_last_number <= n_last_number;
            r_last_term   <= n_last_term;
            r_pend_g      <= n_pend_g;
            r_pend_s      <= n_pend_s;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_key_addr <= n_key_addr;
        r_key_src  <= n_key_src;
        r_key_sp   <= n_key_sp;
        r_out      <= n_out;
    end

    // Table memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (grp_we) r_grp_mem[wr_addr] <= clause_wd;
        if (src_we) r_src_mem[wr_addr] <= clause_wd;
        if (meta_we) r_meta_mem[wr_addr] <= meta_wd;
        r_grp_rd  <= r_grp_mem[rd_addr];
        r_src_rd  <= r_src_mem[rd_addr];
        r_meta_rd <= r_meta_mem[rd_addr];
    end

    // A scan starts only with the result register free, so it stays free.
    a_scan_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("result register busy during a scan");

    // The scan index stays below the active entry count.
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) < r_count[r_active]))
        else $error("scan index beyond entry count");

    // The load count and both bank entry counts never pass the table size.
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_count <= MAX_CNT) && (r_count[0] <= MAX_CNT) && (r_count[1] <= MAX_CNT))
        else $error("entry count beyond table size");

    // No command is taken while a scan runs.
    a_no_take_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_cmd_ready)
        else $error("command taken during a scan");

endmodule

[tb/first_match_prefix_policy_tb.sv]
// Testbench for the first-match IPv6 prefix policy table: directed table, then random loads.
`timescale 1ns / 1ps
module first_match_prefix_policy_tb;
    import fmpp_pkg::*;

    localparam int MAX_ENTRIES = 64;
    localparam int ITEM_GOAL   = 1200;
    localparam int ITEM_W      = $bits(t_item);
    localparam logic [1:0] ACT_REJECT = 2'd1;
    localparam logic [1:0] ACT_POLICY = 2'd3;
    localparam logic [2:0] OP_BAD6    = 3'd6;
    localparam logic [2:0] OP_BAD7    = 3'd7;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_item   i_item;
    logic    empty;
    logic    pop;
    t_result o_result;

    first_match_prefix_policy #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the policy table.
    logic [127:0] grp_net [2][MAX_ENTRIES];
    logic [7:0]   grp_len [2][MAX_ENTRIES];
    bit           grp_on  [2][MAX_ENTRIES];
    logic [127:0] src_net [2][MAX_ENTRIES];
    logic [7:0]   src_len [2][MAX_ENTRIES];
    bit           src_on  [2][MAX_ENTRIES];
    logic [1:0]   ent_act [2][MAX_ENTRIES];
    int unsigned  bank_entries [2];
    logic [1:0]   bank_dflt [2];
    bit           live_bank;
    int unsigned  pend_cnt;
    bit           pend_err;
    logic [31:0]  prev_num;
    logic [31:0]  prev_term;

    t_result     decision_q [$];
    int          errors;
    int          sent_items;
    int          idle_pct;
    int          hold_left;
    logic [135:0] prefix_pool [$];

    function automatic logic [127:0] net_mask(input logic [7:0] len);
        if (len == 8'd0) return '0;
        if (len >= MAX_PREFIX) return '1;
        return ~({128{1'b1}} >> len);
    endfunction

    function automatic bit covers(input logic [127:0] net, input logic [7:0] len,
                                  input logic [127:0] a);
        return (a & net_mask(len)) == net;
    endfunction

    // Compute the decision for one accepted transaction and update the shadow table.
    function automatic t_result policy_decide(input t_item it);
        t_result r;
        bit spare;
        bit decided;
        bit ok;
        int unsigned slot;
        logic [127:0] a;
        logic [127:0] s;
        r = '0;
        spare = ~live_bank;
        slot = pend_cnt;
        a = {it.addr_hi, it.addr_lo};
        s = {it.src_hi, it.src_lo};
        case (it.opcode)
            OP_EVAL: begin
                decided = 0;
                for (int i = 0; i < bank_entries[live_bank] && !decided; i++) begin
                    if (grp_on[live_bank][i] &&
                        !covers(grp_net[live_bank][i], grp_len[live_bank][i], a)) continue;
                    if (src_on[live_bank][i] && (!it.src_present ||
                        !covers(src_net[live_bank][i], src_len[live_bank][i], s))) continue;
                    if (ent_act[live_bank][i] != ACT_NEXT) begin
                        r.result_action = ent_act[live_bank][i];
                        decided = 1;
                    end
                end
                if (!decided) r.result_action = bank_dflt[live_bank];
            end
            OP_BEGIN: begin
                pend_cnt = 0;
                pend_err = 0;
                prev_num = '0;
                prev_term = '0;
                grp_on[spare][0] = 0;
                src_on[spare][0] = 0;
            end
            OP_GROUP, OP_SOURCE: begin
                if (pend_cnt >= MAX_ENTRIES) begin
                    pend_err = 1;
                    r.status = ST_FULL;
                end else begin
                    ok = !it.clause_present ||
                         (it.prefix_len <= MAX_PREFIX && (a & net_mask(it.prefix_len)) == a);
                    if (!ok) begin
                        pend_err = 1;
                        r.status = ST_INVALID;
                    end else if (it.opcode == OP_GROUP) begin
                        grp_on[spare][slot] = it.clause_present;
                        grp_net[spare][slot] = a;
                        grp_len[spare][slot] = it.prefix_len;
                    end else begin
                        src_on[spare][slot] = it.clause_present;
                        src_net[spare][slot] = a;
                        src_len[spare][slot] = it.prefix_len;
                    end
                end
            end
            OP_APPEND: begin
                if (pend_cnt >= MAX_ENTRIES) begin
                    pend_err = 1;
                    r.status = ST_FULL;
                end else if (it.entry_number == 0 || it.entry_number < prev_num ||
                             (it.entry_number == prev_num && it.entry_term <= prev_term)) begin
                    pend_err = 1;
                    r.status = ST_INVALID;
                end else begin
                    ent_act[spare][slot] = it.action;
                    pend_cnt++;
                    prev_num = it.entry_number;
                    prev_term = it.entry_term;
                    if (pend_cnt < MAX_ENTRIES) begin
                        grp_on[spare][pend_cnt] = 0;
                        src_on[spare][pend_cnt] = 0;
                    end
                end
            end
            OP_COMMIT: begin
                if (pend_err || it.action == ACT_NEXT) begin
                    r.status = ST_INVALID;
                end else begin
                    bank_entries[spare] = pend_cnt;
                    bank_dflt[spare] = it.action;
                    live_bank = spare;
                    pend_err = 1;
                end
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH %s at %0t", msg, $realtime);
        errors++;
    endtask

    // Offer one transaction, with random idle cycles, and record its decision on acceptance.
    task automatic send(input t_item it);
        idle_pct = (sent_items > 650 && sent_items < 850) ? 0 : 21;
        if (sent_items == 400) hold_left = 400;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decision_q.push_back(policy_decide(it));
        sent_items++;
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic t_item blank(input logic [2:0] op);
        t_item it;
        it = '0;
        it.opcode = op;
        return it;
    endfunction

    function automatic t_item clause(input logic [2:0] op, input logic [127:0] net,
                                     input logic [7:0] len, input bit present);
        t_item it;
        it = blank(op);
        {it.addr_hi, it.addr_lo} = net;
        it.prefix_len = len;
        it.clause_present = present;
        return it;
    endfunction

    function automatic t_item append(input logic [31:0] num, input logic [31:0] term,
                                     input logic [1:0] act);
        t_item it;
        it = blank(OP_APPEND);
        it.entry_number = num;
        it.entry_term = term;
        it.action = act;
        return it;
    endfunction

    function automatic t_item commit(input logic [1:0] act);
        t_item it;
        it = blank(OP_COMMIT);
        it.action = act;
        return it;
    endfunction

    function automatic t_item evaluate(input logic [127:0] g, input logic [127:0] s,
                                       input bit has_src);
        t_item it;
        it = blank(OP_EVAL);
        {it.addr_hi, it.addr_lo} = g;
        {it.src_hi, it.src_lo} = s;
        it.src_present = has_src;
        return it;
    endfunction

    // Address inside a recently loaded prefix, or a fully random one.
    function automatic logic [127:0] pick_addr();
        logic [135:0] p;
        if (prefix_pool.size() == 0 || $urandom_range(99) < 20) return rand128();
        p = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
        return p[135:8] | (rand128() & ~net_mask(p[7:0]));
    endfunction

    // Random clause, mostly legal, sometimes with host bits or an oversize length.
    task automatic random_clause(input logic [2:0] op);
        logic [7:0] len;
        logic [127:0] net;
        int sel;
        sel = $urandom_range(9);
        len = (sel == 0) ? 8'd0 : (sel == 1) ? MAX_PREFIX : 8'($urandom_range(128));
        net = rand128() & net_mask(len);
        sel = $urandom_range(39);
        if (sel == 0) len = 8'($urandom_range(255, 129));
        else if (sel == 1 && len != MAX_PREFIX) net[$urandom_range(127 - len)] = 1'b1;
        if (prefix_pool.size() >= 32) void'(prefix_pool.pop_front());
        prefix_pool.push_back({net, len});
        send(clause(op, net, len, $urandom_range(9) != 0));
    endtask

    // One load of n entries with a commit, followed by a burst of evaluates.
    task automatic load_and_probe(input int n);
        logic [31:0] num;
        logic [31:0] term;
        logic [1:0] act;
        num = ($urandom_range(3) == 0) ? $urandom : 32'd0;
        term = $urandom;
        send(blank(OP_BEGIN));
        for (int e = 0; e < n; e++) begin
            if ($urandom_range(99) < 60) random_clause(OP_GROUP);
            if ($urandom_range(99) < 45) random_clause(OP_SOURCE);
            if ($urandom_range(1)) begin
                num = num + 32'($urandom_range(3, 1));
                term = $urandom;
            end else begin
                term = term + 1;
                if (num == 0) num = 1;
            end
            if ($urandom_range(39) == 0) send(append($urandom_range(1) ? 32'd0 : num - 1,
                                                     term, 2'($urandom)));
            else send(append(num, term, 2'($urandom)));
        end
        act = 2'($urandom);
        send(commit(act));
        for (int k = $urandom_range(12, 2); k > 0; k--)
            send(evaluate(pick_addr(), pick_addr(), $urandom_range(4) != 0));
    endtask

    // Result side: random pop idling plus one long hold-off, checking on each acceptance.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (decision_q.size() == 0) begin
                report_mismatch("unexpected transaction");
            end else begin
                want = decision_q.pop_front();
                if (o_result.result_action !== want.result_action)
                    report_mismatch($sformatf("result_action: got %0d, expected %0d",
                                              o_result.result_action, want.result_action));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status: got %0d, expected %0d",
                                              o_result.status, want.status));
            end
        end
    end

    // Directed stimulus; chk marks rows whose decision is typed in.
    typedef struct {
        t_item   it;
        bit      chk;
        t_result want;
    } t_row;

    t_row rows [$];

    function automatic t_row row(input t_item it, input bit chk,
                                 input logic [1:0] act, input logic [1:0] st);
        t_row r;
        r.it = it;
        r.chk = chk;
        r.want.result_action = act;
        r.want.status = st;
        return r;
    endfunction

    initial begin
        int waited;
        t_result got;
        errors = 0;
        sent_items = 0;
        idle_pct = 21;
        hold_left = 0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        live_bank = 0;
        pend_cnt = 0;
        pend_err = 0;
        prev_num = '0;
        prev_term = '0;
        for (int b = 0; b < 2; b++) begin
            bank_entries[b] = 0;
            bank_dflt[b] = ACT_ACCEPT;
        end
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty table after reset, unknown opcodes, default next-entry refused.
        rows.push_back(row(evaluate('1, '1, 1), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(blank(OP_BAD6), 1, ACT_ACCEPT, ST_INVALID));
        rows.push_back(row(blank(OP_BAD7), 1, ACT_ACCEPT, ST_INVALID));
        rows.push_back(row(commit(ACT_NEXT), 1, ACT_ACCEPT, ST_INVALID));
        // Three-entry table: catch-all group with source /128, group /64 next-entry, bare entry.
        rows.push_back(row(blank(OP_BEGIN), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(clause(OP_GROUP, '0, 8'd0, 1), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(clause(OP_SOURCE, '1, MAX_PREFIX, 1), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(append(32'd1, 32'd0, ACT_REJECT), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(clause(OP_GROUP, {64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 8'd64, 1),
                           1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(append(32'd1, 32'd5, ACT_NEXT), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(append('1, '1, ACT_POLICY), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(commit(ACT_REJECT), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(evaluate('1, '1, 1), 0, '0, '0));
        rows.push_back(row(evaluate('1, '1, 0), 0, '0, '0));
        rows.push_back(row(evaluate('0, '0, 1), 0, '0, '0));
        // A second commit needs a new begin; then rejected loads and an absent clause that passes.
        rows.push_back(row(commit(ACT_ACCEPT), 1, ACT_ACCEPT, ST_INVALID));
        rows.push_back(row(blank(OP_BEGIN), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(clause(OP_GROUP, '0, 8'd129, 1), 1, ACT_ACCEPT, ST_INVALID));
        rows.push_back(row(clause(OP_SOURCE, 128'd1, 8'd127, 1), 1, ACT_ACCEPT, ST_INVALID));
        rows.push_back(row(clause(OP_SOURCE, 128'd1, 8'd255, 0), 1, ACT_ACCEPT, ST_OK));
        rows.push_back(row(append(32'd0, '1, ACT_ACCEPT), 1, ACT_ACCEPT, ST_INVALID));
        rows.push_back(row(commit(ACT_ACCEPT), 1, ACT_ACCEPT, ST_INVALID));
        rows.push_back(row(evaluate('1, '0, 0), 0, '0, '0));

        foreach (rows[i]) begin
            send(rows[i].it);
            if (rows[i].chk) begin
                got = decision_q[$];
                if (got !== rows[i].want)
                    report_mismatch($sformatf("directed row %0d predicts %0d/%0d", i,
                                              got.result_action, got.status));
            end
        end

        // Random part: mostly well-formed loads, some full tables, some noise.
        while (sent_items < ITEM_GOAL) begin
            case ($urandom_range(9))
                0: load_and_probe($urandom_range(MAX_ENTRIES + 2, MAX_ENTRIES - 1));
                1, 2: begin
                    t_item it;
                    it = ITEM_W'({$urandom, rand128(), rand128(), rand128(), $urandom});
                    it.opcode = 3'($urandom);
                    send(it);
                end
                default: load_and_probe($urandom_range(8));
            endcase
        end
        @(negedge i_clk);
        push = 1'b0;

        waited = 0;
        while (decision_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (decision_q.size() != 0)
            report_mismatch($sformatf("%0d decisions never delivered", decision_q.size()));
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/fmpp_pkg.sv
rtl/core/fmpp_front.sv
rtl/core/fmpp_back.sv
rtl/core/first_match_prefix_policy.sv
tb/first_match_prefix_policy_tb.sv
